>>> hw/rtl/iva_pkg.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator package
// Sizes, derived widths and the command and status words between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package iva_pkg;

	localparam int NUM_VECTORS       = 256;
	localparam int VECTORS_PER_LEVEL = 16;
	localparam int COUNT_WIDTH       = 8;

	localparam int LEVEL_W = 4;
	localparam int OUT_W   = 8;
	localparam int VEC_W   = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;
	localparam int CNT_W   = $clog2(VECTORS_PER_LEVEL + 1);
	localparam int SUM_W   = LEVEL_W + CNT_W + 1;
	localparam int FULL_W  = (SUM_W > VEC_W + 1) ? SUM_W : VEC_W + 1;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	typedef struct packed {
		logic start;
		logic scan;
		logic finish;
	} iva_cmd_t;

	typedef struct packed {
		logic scan_done;
		logic out_free;
	} iva_sts_t;

endpackage

>>> hw/rtl/iva_ctrl.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator controller
// Sequences one request: accept, window scan, write-back and result load.
// ----------------------------------------------------------------------------
module iva_ctrl import iva_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	output logic     s_tready,
	input  iva_sts_t sts,
	output iva_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_WRITE = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	assign s_tready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.finish = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/iva_datapath.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator datapath
// Vector table memory, window scan with best-candidate tracking, write-back
// and the output register.
// ----------------------------------------------------------------------------
module iva_datapath import iva_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  iva_cmd_t               cmd,
	output iva_sts_t               sts,
	input  logic [LEVEL_W-1:0]     level,
	input  logic                   shareable,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic                   granted,
	output logic [OUT_W-1:0]       vector,
	output logic [OUT_W-1:0]       users_after
);

	logic [COUNT_WIDTH-1:0] cnt_mem [NUM_VECTORS];
	logic                   mark_mem [NUM_VECTORS];
	logic [NUM_VECTORS-1:0] entry_vld_q;

	logic [LEVEL_W-1:0]     level_q;
	logic                   share_q;
	logic [CNT_W-1:0]       idx_q;
	logic                   have_q;
	logic                   done_q;
	logic [VEC_W-1:0]       pick_q;
	logic [COUNT_WIDTH-1:0] best_cnt_q;

	logic                   rd_vld_s1;
	logic [VEC_W-1:0]       rd_addr_s1;
	logic [COUNT_WIDTH-1:0] rd_cnt_s1;
	logic                   rd_mark_s1;
	logic                   rd_entry_s1;

	logic                   out_vld_q;
	logic                   granted_q;
	logic [OUT_W-1:0]       vector_q;
	logic [OUT_W-1:0]       users_q;

	logic [FULL_W-1:0]      full_addr;
	logic                   can_issue;
	logic [COUNT_WIDTH-1:0] eff_cnt;
	logic                   eff_mark;
	logic [COUNT_WIDTH-1:0] new_cnt;

	assign full_addr = FULL_W'(level_q) * FULL_W'(VECTORS_PER_LEVEL) + FULL_W'(idx_q);
	assign can_issue = (idx_q < CNT_W'(VECTORS_PER_LEVEL)) &&
	                   (full_addr < FULL_W'(NUM_VECTORS));
	assign eff_cnt   = rd_entry_s1 ? rd_cnt_s1 : '0;
	assign eff_mark  = rd_entry_s1 & rd_mark_s1;
	assign new_cnt   = (best_cnt_q == COUNT_MAX) ? best_cnt_q : best_cnt_q + COUNT_WIDTH'(1);

	assign sts.scan_done = done_q || (!can_issue && !rd_vld_s1);
	assign sts.out_free  = !out_vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.scan && can_issue) begin
			rd_cnt_s1  <= cnt_mem[full_addr[VEC_W-1:0]];
			rd_mark_s1 <= mark_mem[full_addr[VEC_W-1:0]];
		end
		if (cmd.finish && have_q) begin
			cnt_mem[pick_q] <= new_cnt;
			if (best_cnt_q == '0) begin
				mark_mem[pick_q] <= share_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			level_q <= level;
			share_q <= shareable;
		end
		if (cmd.scan && can_issue) begin
			rd_addr_s1  <= full_addr[VEC_W-1:0];
			rd_entry_s1 <= entry_vld_q[full_addr[VEC_W-1:0]];
		end
		if (cmd.scan && rd_vld_s1 && !done_q) begin
			if (eff_cnt == '0) begin
				pick_q     <= rd_addr_s1;
				best_cnt_q <= '0;
			end else if (eff_mark && share_q && (!have_q || best_cnt_q > eff_cnt)) begin
				pick_q     <= rd_addr_s1;
				best_cnt_q <= eff_cnt;
			end
		end
		if (cmd.finish) begin
			granted_q <= have_q;
			vector_q  <= have_q ? OUT_W'(pick_q) : '0;
			users_q   <= have_q ? OUT_W'(new_cnt) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_vld_q <= '0;
			idx_q       <= '0;
			have_q      <= 1'b0;
			done_q      <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q     <= '0;
				have_q    <= 1'b0;
				done_q    <= 1'b0;
				rd_vld_s1 <= 1'b0;
			end else if (cmd.scan) begin
				rd_vld_s1 <= can_issue && !done_q;
				if (can_issue) begin
					idx_q <= idx_q + CNT_W'(1);
				end
				if (rd_vld_s1 && !done_q) begin
					if (eff_cnt == '0) begin
						have_q <= 1'b1;
						done_q <= 1'b1;
					end else if (eff_mark && share_q && (!have_q || best_cnt_q > eff_cnt)) begin
						have_q <= 1'b1;
					end
				end
			end
			if (cmd.finish && have_q) begin
				entry_vld_q[pick_q] <= 1'b1;
			end
			if (cmd.finish) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign m_tvalid    = out_vld_q;
	assign granted     = granted_q;
	assign vector      = vector_q;
	assign users_after = users_q;

endmodule

>>> hw/rtl/interrupt_vector_allocator.sv
// ----------------------------------------------------------------------------
// Interrupt vector allocator
// Allocates a vector from a priority level's window on each request.
// ----------------------------------------------------------------------------
// A request word on the s_ side names a level and whether the requester can
// share a vector. The block reads the level's window of vectors one per
// cycle from the vector table, takes the first free vector or else the
// shareable vector with the fewest users, and writes the new user count back.
// One result word per request leaves on the m_ side.
// The scan ends early at a free vector. The single table read port is why the
// window is read one vector at a time. One request is in work at a time;
// s_tready is high only while the block is idle, so the next request can be
// accepted in the cycle after the result is loaded.
// The result sits in an output register, so the next request is accepted
// while it waits. If the receiver stalls, the following request stops before
// write-back until the output register is taken.
// Reset clears all user counts and sharing marks at once through per-entry
// valid bits; no clearing pass is needed.
module interrupt_vector_allocator import iva_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // level[3:0], shareable[4], zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // granted[0], vector[8:1], users_after[16:9], zero
);

	iva_cmd_t         cmd;
	iva_sts_t         sts;
	logic             granted;
	logic [OUT_W-1:0] vector;
	logic [OUT_W-1:0] users_after;

	iva_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	iva_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.level       (s_tdata[LEVEL_W-1:0]),
		.shareable   (s_tdata[LEVEL_W]),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.granted     (granted),
		.vector      (vector),
		.users_after (users_after)
	);

	assign m_tdata = {7'd0, users_after, vector, granted};

	property p_busy_after_accept;
		@(posedge clk) disable iff (!arst_n)
			(s_tvalid && s_tready) |=> !s_tready;
	endproperty
	a_busy_after_accept: assert property (p_busy_after_accept)
		else $error("Input was still ready right after a request was accepted.");

	property p_fail_is_zero;
		@(posedge clk) disable iff (!arst_n)
			(m_tvalid && !m_tdata[0]) |-> (m_tdata[16:1] == 16'd0);
	endproperty
	a_fail_is_zero: assert property (p_fail_is_zero)
		else $error("A failed allocation carried a nonzero vector or count.");

	property p_result_from_finish;
		@(posedge clk) disable iff (!arst_n)
			$rose(m_tvalid) |-> $past(cmd.finish);
	endproperty
	a_result_from_finish: assert property (p_result_from_finish)
		else $error("A result appeared without a write-back step.");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Interrupt vector allocator testbench
// Drives allocation requests with random gaps and a randomly stalling receiver.
// A ledger keeps its own copy of the vector table, predicts each result word
// when its request is accepted, and checks every result word field by field.
// The run covers full and refused windows, vector sharing with fewest-user
// selection, and a vector driven past its user count ceiling.
// ----------------------------------------------------------------------------
module tb;
	import iva_pkg::*;

	localparam int IDLE_LIMIT  = 4000;
	localparam int RANDOM_REQS = 420;
	localparam int TOP_LEVEL   = (1 << LEVEL_W) - 1;

	typedef struct packed {
		logic       granted;
		logic [7:0] vector;
		logic [7:0] users_after;
	} grant_t;

	class vector_ledger;
		logic [COUNT_WIDTH-1:0] users [NUM_VECTORS];
		bit                     shared [NUM_VECTORS];
		grant_t                 grants_due [$];
		int errors      = 0;
		int requests    = 0;
		int grants      = 0;
		int refusals    = 0;
		int joined      = 0;
		int at_ceiling  = 0;

		function new();
			foreach (users[i]) begin
				users[i]  = '0;
				shared[i] = 1'b0;
			end
		endfunction

		function void note_request(logic [LEVEL_W-1:0] level, logic shareable);
			int     base;
			int     v;
			int     pick;
			bit     have;
			grant_t g;
			base = level * VECTORS_PER_LEVEL;
			have = 1'b0;
			pick = 0;
			g    = '0;
			for (int i = 0; i < VECTORS_PER_LEVEL; i++) begin
				v = base + i;
				if (v >= NUM_VECTORS)
					break;
				if (users[v] == 0) begin
					have = 1'b1;
					pick = v;
					break;
				end
				if (shared[v] && shareable && (!have || users[pick] > users[v])) begin
					have = 1'b1;
					pick = v;
				end
			end
			requests++;
			if (have) begin
				grants++;
				if (users[pick] == 0)
					shared[pick] = shareable;
				else
					joined++;
				if (users[pick] != COUNT_MAX)
					users[pick] = users[pick] + 1'b1;
				else
					at_ceiling++;
				g.granted     = 1'b1;
				g.vector      = pick[7:0];
				g.users_after = 8'(users[pick]);
			end else begin
				refusals++;
			end
			grants_due.push_back(g);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t ns: %s", $time, msg);
		endtask

		task check_result(logic [OUT_TDATA_W-1:0] word);
			grant_t want;
			grant_t got;
			got.granted     = word[0];
			got.vector      = word[8:1];
			got.users_after = word[16:9];
			if (grants_due.size() == 0) begin
				report($sformatf("result word %h with no request outstanding", word));
				return;
			end
			want = grants_due.pop_front();
			if (got.granted !== want.granted)
				report($sformatf("granted %b, predicted %b", got.granted, want.granted));
			if (got.vector !== want.vector)
				report($sformatf("vector %0d, predicted %0d", got.vector, want.vector));
			if (got.users_after !== want.users_after)
				report($sformatf("users_after %0d, predicted %0d (vector %0d)",
					got.users_after, want.users_after, want.vector));
		endtask
	endclass

	logic                   clk      = 1'b0;
	logic                   arst_n   = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata  = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	vector_ledger ledger = new();
	int           send_seq = 0;
	int           idle_cycles = 0;

	interrupt_vector_allocator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Every third stretch of forty words runs with no idle cycles at all.
	function automatic int draw_wait(input int seq);
		if ((seq / 40) % 3 == 2)
			return 0;
		return $urandom_range(0, 17);
	endfunction

	task automatic request_vector(input logic [LEVEL_W-1:0] level, input logic shareable);
		int gap;
		gap = draw_wait(send_seq);
		send_seq++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - LEVEL_W - 1){1'b0}}, shareable, level};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ledger.note_request(level, shareable);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (ledger.grants_due.size() != 0);
		@(posedge clk);
	endtask

	initial begin
		int                 sat_level;
		int                 sat_slot;
		logic [LEVEL_W-1:0] hot [3];
		logic [LEVEL_W-1:0] level;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		request_vector(4'd0, 1'b0);
		request_vector(4'd0, 1'b1);
		request_vector(4'd0, 1'b1);
		request_vector(4'd5, 1'b1);
		request_vector(4'd10, 1'b0);
		for (int i = 0; i < VECTORS_PER_LEVEL; i++)
			request_vector(LEVEL_W'(TOP_LEVEL), 1'b0);
		request_vector(LEVEL_W'(TOP_LEVEL), 1'b1);
		request_vector(LEVEL_W'(TOP_LEVEL), 1'b0);
		drain_results();

		// Fill one window with a single shareable vector, then pile shared
		// users onto it until its count sits at the ceiling.
		sat_level = $urandom_range(1, 4);
		sat_slot  = $urandom_range(0, VECTORS_PER_LEVEL - 1);
		for (int i = 0; i < VECTORS_PER_LEVEL; i++)
			request_vector(LEVEL_W'(sat_level), i == sat_slot);
		for (int n = 0; n < (1 << COUNT_WIDTH) + 6; n++) begin
			if ($urandom_range(0, 9) == 0)
				request_vector(LEVEL_W'(sat_level), 1'b0);
			request_vector(LEVEL_W'(sat_level), 1'b1);
		end
		drain_results();

		foreach (hot[k])
			hot[k] = LEVEL_W'($urandom_range(6, TOP_LEVEL - 1));
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if ($urandom_range(0, 9) < 6)
				level = hot[$urandom_range(0, 2)];
			else
				level = LEVEL_W'($urandom_range(0, TOP_LEVEL));
			request_vector(level, $urandom_range(0, 3) != 0);
			if (n % 150 == 149)
				drain_results();
		end
		drain_results();
		repeat (VECTORS_PER_LEVEL + 8) @(posedge clk);

		$display("requests %0d: %0d granted, %0d refused", ledger.requests, ledger.grants,
			ledger.refusals);
		$display("grants onto vectors in use %0d, grants with the count at its ceiling %0d",
			ledger.joined, ledger.at_ceiling);
		if (ledger.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		int stall;
		int seq;
		seq = 20;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = draw_wait(seq);
			seq++;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			ledger.check_result(m_tdata);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
			$display("TB_ERROR");
			$finish;
		end
	end

endmodule

>>> filelist.f
hw/rtl/iva_pkg.sv
hw/rtl/iva_ctrl.sv
hw/rtl/iva_datapath.sv
hw/rtl/interrupt_vector_allocator.sv
tb/tb.sv
